### design/range_argmin_segment_tree_macros.svh
`ifndef RANGE_ARGMIN_SEGMENT_TREE_MACROS_SVH
`define RANGE_ARGMIN_SEGMENT_TREE_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define RASG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that cons holds in every cycle in which ante holds.
`define RASG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/rasg_pkg.sv
`timescale 1ns / 1ps

package rasg_pkg;

  // Tree geometry
  localparam int unsigned LEAVES_LOG2 = 10;
  localparam int unsigned LEAVES      = 1 << LEAVES_LOG2;
  localparam int unsigned NODES       = 2 * LEAVES;
  localparam int unsigned NODE_AW     = LEAVES_LOG2 + 1;  // node index into the store
  localparam int unsigned IDX_W       = NODE_AW + 1;      // walk index, may reach NODES
  localparam int unsigned POS_BITS    = LEAVES_LOG2;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned NODE_W      = VALUE_BITS + POS_BITS;

  // Stream field layout
  localparam int unsigned POS_FW     = 10;
  localparam int unsigned END_FW     = 11;
  localparam int unsigned VAL_FW     = 32;
  localparam int unsigned POS_LSB    = 0;
  localparam int unsigned END_LSB    = POS_LSB + POS_FW;
  localparam int unsigned VAL_LSB    = END_LSB + END_FW;
  localparam int unsigned IN_DATA_W  = ((POS_FW + END_FW + VAL_FW + 7) / 8) * 8;
  localparam int unsigned OUT_POS_LSB = 0;
  localparam int unsigned OUT_VAL_LSB = OUT_POS_LSB + POS_FW;
  localparam int unsigned OUT_DATA_W = ((POS_FW + VAL_FW + 7) / 8) * 8;

  // Operation codes carried in tuser
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   pos;
  } node_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_L,
    ST_QRY_R,
    ST_QRY_FIN
  } state_e;

endpackage

### design/rasg_ram.sv
`timescale 1ns / 1ps

module rasg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/rasg_better.sv
`timescale 1ns / 1ps

// Shared compare unit: take the candidate when there is no incumbent, or when it
// has the smaller value, or the same value at a smaller position.
module rasg_better (
  input  rasg_pkg::node_t cand_i,
  input  rasg_pkg::node_t inc_i,
  input  logic            inc_valid_i,
  output logic            take_o
);

  logic val_lt;
  logic val_eq;
  logic pos_lt;

  assign val_lt = cand_i.value < inc_i.value;
  assign val_eq = cand_i.value == inc_i.value;
  assign pos_lt = cand_i.pos < inc_i.pos;
  assign take_o = !inc_valid_i || val_lt || (val_eq && pos_lt);

endmodule

### design/range_argmin_segment_tree.sv
`timescale 1ns / 1ps
// Range argmin segment tree over 1024 positions. Each node of a bottom-up tree
// keeps the smallest 32-bit value of its span and the position where it sits;
// on equal values the smaller position wins. An update (tuser = 0) writes one
// leaf and recombines its path to the root, and produces no output transfer;
// a position beyond the tree is dropped. A query (tuser = 1) over the half-open
// range [position, range_end) returns one transfer with the position and value
// of the minimum and found = 1, or all zeros with found = 0 for an empty range;
// range_end above 1024 is saturated. All nodes sit in one RAM that is never
// written and read in the same cycle, so each cycle moves at most one node: an
// update alternates a sibling read and a parent write from its leaf up to the
// root before the next input is taken, a query checks the left and then the
// right end of its range at each tree level it walks, and an empty query goes
// straight to its last step; a query also holds in its last step for as long
// as a stalled receiver keeps the output register full. One finished result
// waits in an output register while the next item is processed. After reset
// the block writes the initial tree (all-ones values, each node holding the
// first position of its span) and keeps s_axis_tready low until that is done.
`include "range_argmin_segment_tree_macros.svh"

module range_argmin_segment_tree (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // position [9:0], range_end [20:10], new_value [52:21], zero pad above
  input  logic [rasg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func [0]
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // min_position [9:0], min_value [41:10], zero pad above
  output logic [rasg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // found [0]
  output logic [0:0]                       m_axis_tuser
);

  localparam int unsigned AW = rasg_pkg::NODE_AW;
  localparam int unsigned IW = rasg_pkg::IDX_W;
  localparam int unsigned PW = rasg_pkg::POS_BITS;
  localparam int unsigned SW = rasg_pkg::POS_BITS + 1;
  localparam int unsigned VB = rasg_pkg::VALUE_BITS;

  // Input fields
  logic                       in_func;
  logic [rasg_pkg::POS_FW-1:0] in_pos;
  logic [rasg_pkg::END_FW-1:0] in_end;
  logic [rasg_pkg::VAL_FW-1:0] in_val;

  assign in_func = s_axis_tuser[0];
  assign in_pos  = s_axis_tdata[rasg_pkg::POS_LSB +: rasg_pkg::POS_FW];
  assign in_end  = s_axis_tdata[rasg_pkg::END_LSB +: rasg_pkg::END_FW];
  assign in_val  = s_axis_tdata[rasg_pkg::VAL_LSB +: rasg_pkg::VAL_FW];

  // Sequencer state and walk registers
  rasg_pkg::state_e state_q, state_d;
  logic [IW-1:0]    lo_q, lo_d;        // clear index, update path node, query left
  logic [IW-1:0]    r_q, r_d;          // query right bound (exclusive)
  logic [PW-1:0]    clr_pos_q, clr_pos_d;
  logic [SW-1:0]    clr_stride_q, clr_stride_d;
  rasg_pkg::node_t  best_q, best_d;    // running minimum, or the new path node
  logic             have_q, have_d;
  logic             pend_q, pend_d;    // RAM read data is to be folded this cycle

  // Output register
  logic                        out_valid_q;
  logic [rasg_pkg::POS_FW-1:0] out_pos_q;
  logic [rasg_pkg::VAL_FW-1:0] out_val_q;
  logic                        out_found_q;
  logic                        out_free;
  logic                        out_load;

  // RAM port
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  rasg_pkg::node_t             ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [rasg_pkg::NODE_W-1:0] ram_rdata;
  rasg_pkg::node_t             rd_node;

  // Accept-time decode
  logic          accept;
  logic          upd_ok;
  logic [AW-1:0] end_sat;
  logic          qry_nonempty;
  logic [IW-1:0] leaf_idx;
  logic [IW-1:0] r_start;
  logic          take;

  // Clear sweep helpers
  logic [IW-1:0] clr_next;
  logic          clr_next_pow2;
  logic [IW-1:0] r_dec;

  assign s_axis_tready = (state_q == rasg_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign upd_ok       = 32'(in_pos) < 32'(rasg_pkg::LEAVES);
  assign end_sat      = (32'(in_end) > 32'(rasg_pkg::LEAVES)) ? AW'(rasg_pkg::LEAVES)
                                                              : AW'(in_end);
  assign qry_nonempty = 32'(in_pos) < 32'(end_sat);
  assign leaf_idx     = IW'(32'(rasg_pkg::LEAVES) + 32'(in_pos));
  assign r_start      = IW'(32'(rasg_pkg::LEAVES) + 32'(end_sat));

  assign clr_next      = lo_q + IW'(1);
  assign clr_next_pow2 = (clr_next & (clr_next - IW'(1))) == '0;
  assign r_dec         = r_q - IW'(1);

  assign rd_node = ram_rdata;

  rasg_ram #(
    .WIDTH(rasg_pkg::NODE_W),
    .DEPTH(rasg_pkg::NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // One compare unit serves both the update path and the query fold.
  rasg_better u_better (
    .cand_i     (rd_node),
    .inc_i      (best_q),
    .inc_valid_i(have_q),
    .take_o     (take)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rasg_pkg::ST_CLEAR: begin
        if (lo_q[AW-1:0] == '1) begin
          state_d = rasg_pkg::ST_IDLE;
        end
      end
      rasg_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == rasg_pkg::FUNC_UPDATE) begin
            if (upd_ok) begin
              state_d = rasg_pkg::ST_UPD_RD;
            end
          end else begin
            state_d = qry_nonempty ? rasg_pkg::ST_QRY_L : rasg_pkg::ST_QRY_FIN;
          end
        end
      end
      rasg_pkg::ST_UPD_RD: begin
        state_d = (lo_q == IW'(1)) ? rasg_pkg::ST_IDLE : rasg_pkg::ST_UPD_WR;
      end
      rasg_pkg::ST_UPD_WR: begin
        state_d = rasg_pkg::ST_UPD_RD;
      end
      rasg_pkg::ST_QRY_L: begin
        state_d = (lo_q < r_q) ? rasg_pkg::ST_QRY_R : rasg_pkg::ST_QRY_FIN;
      end
      rasg_pkg::ST_QRY_R: begin
        state_d = rasg_pkg::ST_QRY_L;
      end
      rasg_pkg::ST_QRY_FIN: begin
        if (out_free) begin
          state_d = rasg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rasg_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    lo_d         = lo_q;
    r_d          = r_q;
    clr_pos_d    = clr_pos_q;
    clr_stride_d = clr_stride_q;
    best_d       = best_q;
    have_d       = have_q;
    pend_d       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = lo_q[AW-1:0];
    ram_wdata    = best_q;
    ram_re       = 1'b0;
    ram_raddr    = lo_q[AW-1:0];
    out_load     = 1'b0;

    // Fold the node read last cycle into the running minimum.
    if (pend_q && take) begin
      best_d = rd_node;
      have_d = 1'b1;
    end

    unique case (state_q)
      rasg_pkg::ST_CLEAR: begin
        // Walk the tree level by level; inside a level the first positions
        // step by the span width, which halves at each new level.
        ram_we          = 1'b1;
        ram_wdata.value = '1;
        ram_wdata.pos   = clr_pos_q;
        lo_d            = clr_next;
        if (clr_next_pow2) begin
          clr_stride_d = clr_stride_q >> 1;
          clr_pos_d    = '0;
        end else begin
          clr_pos_d = PW'({1'b0, clr_pos_q} + clr_stride_q);
        end
      end
      rasg_pkg::ST_IDLE: begin
        if (accept) begin
          lo_d = leaf_idx;
          if (in_func == rasg_pkg::FUNC_UPDATE) begin
            best_d.value = VB'(in_val);
            best_d.pos   = PW'(in_pos);
            have_d       = 1'b1;
            if (upd_ok) begin
              ram_we    = 1'b1;
              ram_waddr = leaf_idx[AW-1:0];
              ram_wdata = best_d;
            end
          end else begin
            r_d    = r_start;
            best_d = '0;
            have_d = 1'b0;
          end
        end
      end
      rasg_pkg::ST_UPD_RD: begin
        // Fetch the sibling of the node just written.
        if (lo_q != IW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = lo_q[AW-1:0] ^ AW'(1);
          pend_d    = 1'b1;
        end
      end
      rasg_pkg::ST_UPD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW:1];
        ram_wdata = best_d;
        lo_d      = lo_q >> 1;
      end
      rasg_pkg::ST_QRY_L: begin
        if ((lo_q < r_q) && lo_q[0]) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          lo_d   = lo_q + IW'(1);
        end
      end
      rasg_pkg::ST_QRY_R: begin
        if (r_q[0]) begin
          ram_re    = 1'b1;
          ram_raddr = r_dec[AW-1:0];
          pend_d    = 1'b1;
        end
        // Step one level up; for an odd right bound (r-1)/2 equals r/2.
        lo_d = lo_q >> 1;
        r_d  = r_q >> 1;
      end
      rasg_pkg::ST_QRY_FIN: begin
        out_load = out_free;
      end
      default: begin
        lo_d = lo_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rasg_pkg::ST_CLEAR;
      lo_q         <= IW'(1);
      clr_pos_q    <= '0;
      clr_stride_q <= SW'(rasg_pkg::LEAVES);
      have_q       <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      lo_q         <= lo_d;
      clr_pos_q    <= clr_pos_d;
      clr_stride_q <= clr_stride_d;
      have_q       <= have_d;
      pend_q       <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; best is zeroed at query start, so an empty range
  // reports zeros without extra muxing.
  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    best_q <= best_d;
    if (out_load) begin
      out_pos_q   <= rasg_pkg::POS_FW'(best_q.pos);
      out_val_q   <= rasg_pkg::VAL_FW'(best_q.value);
      out_found_q <= have_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[rasg_pkg::OUT_POS_LSB +: rasg_pkg::POS_FW] = out_pos_q;
    m_axis_tdata[rasg_pkg::OUT_VAL_LSB +: rasg_pkg::VAL_FW] = out_val_q;
  end

  `RASG_ASSERT_IMP(a_ram_single_access, ram_we, !ram_re, "RAM written and read in one cycle")
  `RASG_ASSERT_IMP(a_fold_in_walk, pend_q, (state_q == rasg_pkg::ST_UPD_WR) || (state_q == rasg_pkg::ST_QRY_L) || (state_q == rasg_pkg::ST_QRY_R), "read data pending outside a tree walk")
  `RASG_ASSERT_IMP(a_query_bounds, state_q == rasg_pkg::ST_QRY_R, lo_q <= r_q, "query left end passed right end")
  `RASG_ASSERT(a_result_from_query, $rose(m_axis_tvalid) |-> $past(state_q == rasg_pkg::ST_QRY_FIN), "result appeared without a finished query")
  `RASG_ASSERT_IMP(a_clear_blocks_input, state_q == rasg_pkg::ST_CLEAR, !s_axis_tready && ram_we, "input taken or no write during clearing")

endmodule
